>>> hw/rtl/stoi_pkg.sv
// Shared types, character codes and tables for the string to integer parser.
// Used by stoi_lookup and string_to_integer_any_base; no dependencies.
package stoi_pkg;

    localparam int unsigned MAX_ALPHABET = 16;
    localparam int unsigned IDX_W        = $clog2(MAX_ALPHABET);
    localparam int unsigned LEN_W        = 5;
    localparam int unsigned ACC_W        = 32;
    localparam int unsigned APB_DW       = 64;
    localparam int unsigned APB_AW       = 5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_ALPHA_LEN  = 2'd2;

    // Square of the radix register, so that two digits fold in with one multiply.
    localparam logic [9:0] SQ_TABLE [32] = '{
        10'd0,   10'd1,   10'd4,   10'd9,   10'd16,  10'd25,  10'd36,  10'd49,
        10'd64,  10'd81,  10'd100, 10'd121, 10'd144, 10'd169, 10'd196, 10'd225,
        10'd256, 10'd289, 10'd324, 10'd361, 10'd400, 10'd441, 10'd484, 10'd529,
        10'd576, 10'd625, 10'd676, 10'd729, 10'd784, 10'd841, 10'd900, 10'd961
    };

    typedef logic [MAX_ALPHABET-1:0][7:0] t_alpha;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_match;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_HELD   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

>>> hw/rtl/stoi_lookup.sv
// Finds the first position of a character among the alphabet characters in use.
// Depends on stoi_pkg.
module stoi_lookup (
    input  stoi_pkg::t_alpha                i_alpha,
    input  logic [stoi_pkg::LEN_W-1:0]      i_used,
    input  logic [7:0]                      i_ch,
    output stoi_pkg::t_match                o_match
);
    import stoi_pkg::*;

    always_comb begin
        o_match = '0;
        for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
            if ((LEN_W'(i) < i_used) && (i_alpha[i] == i_ch)) begin
                o_match.hit = 1'b1;
                o_match.idx = IDX_W'(i);
            end
        end
    end

endmodule

>>> hw/rtl/string_to_integer_any_base.sv
// Top level of the string to integer parser with a configurable digit alphabet.
// Depends on stoi_pkg and stoi_lookup.
//
// The block takes one character per clock cycle with no gaps between strings.
// Each character is captured in an input register and handled from there by
// the parse logic, whose longest path is one 32 by 10 bit multiply and add;
// a string terminator loads the result register, which drives the output.
// The input stalls only when a terminator finds the result register still
// full and not being read in the same cycle.
module string_to_integer_any_base (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stoi_pkg::APB_AW-1:0]        paddr,
    input  logic [stoi_pkg::APB_DW-1:0]        pwdata,
    output logic [stoi_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // Character stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,   // [7:0] ch
    // Result stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic signed [stoi_pkg::ACC_W-1:0]  o_m_axis_tdata    // [31:0] value
);
    import stoi_pkg::*;

    logic [63:0]       r_alpha_low;
    logic [63:0]       r_alpha_high;
    logic [LEN_W-1:0]  r_len;

    logic              r_in_vld;
    logic [7:0]        r_in_ch;
    logic              r_out_vld;
    logic [ACC_W-1:0]  r_out_value;

    t_phase            r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [ACC_W-1:0]  r_acc, n_acc;

    t_alpha            w_alpha;
    logic [LEN_W-1:0]  w_used;
    logic              w_alpha_ok;
    logic [7:0]        w_fold;
    t_match            w_cm;
    t_match            w_zm;
    logic [ACC_W-1:0]  w_acc_l;
    logic [ACC_W-1:0]  w_acc_l2;
    logic [ACC_W-1:0]  w_zero_l;
    logic [ACC_W-1:0]  w_feed;
    logic [ACC_W-1:0]  w_fin;
    logic [ACC_W-1:0]  w_val;
    logic              w_is_nul;
    logic              w_stall;
    logic              w_do;
    logic              w_emit;
    logic              w_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_len        <= '0;
        end else if (w_wr) begin
            case (paddr[4:3])
                REG_ALPHA_LOW:  r_alpha_low  <= pwdata;
                REG_ALPHA_HIGH: r_alpha_high <= pwdata;
                REG_ALPHA_LEN:  r_len        <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ALPHA_LOW:  prdata = r_alpha_low;
            REG_ALPHA_HIGH: prdata = r_alpha_high;
            REG_ALPHA_LEN:  prdata = {{(APB_DW-LEN_W){1'b0}}, r_len};
            default:        prdata = '0;
        endcase
    end

    assign w_alpha = {r_alpha_high, r_alpha_low};
    assign w_used  = (r_len > LEN_W'(MAX_ALPHABET)) ? LEN_W'(MAX_ALPHABET) : r_len;

    // The alphabet must be long enough, hold no separators and no repeats.
    always_comb begin
        w_alpha_ok = (r_len >= LEN_W'(2)) && (r_len <= LEN_W'(MAX_ALPHABET));
        for (int i = 0; i < MAX_ALPHABET; i++) begin
            if (LEN_W'(i) < w_used) begin
                if ((w_alpha[i] == CH_NUL) || (w_alpha[i] == CH_PLUS) ||
                    (w_alpha[i] == CH_MINUS) || is_space(w_alpha[i])) begin
                    w_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_ALPHABET; j++) begin
                    if ((LEN_W'(j) < w_used) && (w_alpha[j] == w_alpha[i])) begin
                        w_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Input register
    assign w_is_nul        = (r_in_ch == CH_NUL);
    assign w_stall         = r_in_vld && w_is_nul && r_out_vld && !i_m_axis_tready;
    assign o_s_axis_tready = !w_stall;
    assign w_do            = r_in_vld && !w_stall;
    assign w_emit          = w_do && w_is_nul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_ch <= i_s_axis_tdata;
        end
    end

    // Digit lookup of the current character and of a held zero
    assign w_fold = ((r_in_ch >= CH_LOW_A) && (r_in_ch <= CH_LOW_Z)) ?
                    (r_in_ch - CASE_GAP) : r_in_ch;

    stoi_lookup u_char_lookup (
        .i_alpha (w_alpha),
        .i_used  (w_used),
        .i_ch    (w_fold),
        .o_match (w_cm)
    );

    stoi_lookup u_zero_lookup (
        .i_alpha (w_alpha),
        .i_used  (w_used),
        .i_ch    (CH_ZERO),
        .o_match (w_zm)
    );

    assign w_acc_l  = r_acc * ACC_W'(r_len);
    assign w_acc_l2 = r_acc * ACC_W'(SQ_TABLE[r_len]);
    assign w_zero_l = ACC_W'(w_zm.idx) * ACC_W'(r_len);
    assign w_feed   = w_acc_l + ACC_W'(w_cm.idx);

    assign w_fin = ((r_phase == PH_HELD) && w_zm.hit) ? (w_acc_l + ACC_W'(w_zm.idx)) : r_acc;
    assign w_val = !w_alpha_ok ? '0 : (r_neg ? (ACC_W'(0) - w_fin) : w_fin);

    // Parse state
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (w_do) begin
            if (w_is_nul) begin
                n_phase = PH_SPACE;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                case (r_phase)
                    PH_SPACE, PH_SIGN: begin
                        if ((r_phase == PH_SPACE) && is_space(r_in_ch)) begin
                            n_phase = PH_SPACE;
                        end else if ((r_in_ch == CH_PLUS) || (r_in_ch == CH_MINUS)) begin
                            n_neg   = r_neg ^ (r_in_ch == CH_MINUS);
                            n_phase = PH_SIGN;
                        end else if (r_in_ch == CH_ZERO) begin
                            n_phase = PH_HELD;
                        end else if (w_cm.hit) begin
                            n_acc   = w_feed;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_HELD: begin
                        if (r_in_ch == CH_LOW_X) begin
                            n_phase = PH_DIGITS;
                        end else if (!w_zm.hit) begin
                            n_phase = PH_DONE;
                        end else if (w_cm.hit) begin
                            // The held zero and this character both fold in.
                            n_acc   = w_acc_l2 + w_zero_l + ACC_W'(w_cm.idx);
                            n_phase = PH_DIGITS;
                        end else begin
                            n_acc   = w_acc_l + ACC_W'(w_zm.idx);
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_cm.hit) begin
                            n_acc = w_feed;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value <= w_val;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_value;

`ifndef ASSERT_OFF
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_phase == PH_SPACE) && !r_neg && (r_acc == '0))
        else $error("parse state not cleared after a result");

    a_bad_alphabet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_alpha_ok) |=> r_out_vld && (r_out_value == '0))
        else $error("invalid alphabet gave a nonzero result");

    a_done_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_DONE) && !w_emit) |=> $stable(r_acc) && (r_phase == PH_DONE))
        else $error("accumulator changed after the number ended");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_vld && w_is_nul && r_out_vld)
        else $error("input stalled without a pending result");
`endif

endmodule
